### sv/ttwc_pkg.sv
package ttwc_pkg;

   // Widest token length the command word has to carry (token store of up to 64 bytes).
   localparam int LEN_W = 7;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_EOS   = 2'd2;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   // One finished piece of work for the back end: a token (or an empty token),
   // optionally followed by an end-of-string mark, or the mark alone.
   typedef struct packed {
      logic             has_tok;
      logic             discard;
      logic             eos;
      logic [LEN_W-1:0] len;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] token_byte;
      logic       token_last;
      logic       run_last;
   } rsp_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b <= CHAR_SPACE) || b[7];
   endfunction

endpackage

### sv/ttwc_ram.sv
module ttwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ttwc_fifo.sv
module ttwc_fifo #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   output logic                     full,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output logic                     empty,
   output logic [$clog2(DEPTH):0]   level
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW:0]      rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   assign level    = wr_ptr_ff - rd_ptr_ff;
   assign full     = (level == (AW+1)'(DEPTH));
   assign empty    = (wr_ptr_ff == rd_ptr_ff);
   assign pop_data = mem_ff[rd_ptr_ff[AW-1:0]];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + (AW+1)'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + (AW+1)'(1) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= push_data;
      end
   end

endmodule

### sv/ttwc_front.sv
module ttwc_front #(
   parameter int TOKEN_MAX  = 64,
   parameter int RING_DEPTH = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic [7:0]                      data_byte,
   output logic                            full,
   input  logic [$clog2(RING_DEPTH):0]     free_ptr,
   output logic                            wr_en,
   output logic [$clog2(RING_DEPTH)-1:0]   wr_addr,
   output logic [7:0]                      wr_data,
   input  logic                            cmd_full,
   output logic                            cmd_push,
   output ttwc_pkg::cmd_type               cmd
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int PW = AW + 1;
   localparam int CW = $clog2(TOKEN_MAX + 1);

   localparam logic [2:0] MODE_SKIP    = 3'd0;
   localparam logic [2:0] MODE_SLASH   = 3'd1;
   localparam logic [2:0] MODE_COMMENT = 3'd2;
   localparam logic [2:0] MODE_QUOTED  = 3'd3;
   localparam logic [2:0] MODE_WORD    = 3'd4;

   logic [2:0]    mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] start_ff, start_in;
   logic          in_token;
   logic [CW-1:0] eff_count;
   logic [PW-1:0] wr_ptr;
   logic [PW-1:0] occupancy;
   logic          ring_full;
   logic          accept;
   logic          space_byte;
   logic          nul_byte;

   // The token being collected sits just above the committed tokens in the ring.
   assign in_token   = (mode_ff == MODE_SLASH) || (mode_ff == MODE_QUOTED) ||
                       (mode_ff == MODE_WORD);
   assign eff_count  = in_token ? count_ff : '0;
   assign wr_ptr     = start_ff + PW'(eff_count);
   assign occupancy  = wr_ptr - free_ptr;
   assign ring_full  = (occupancy >= PW'(RING_DEPTH));
   assign full       = ring_full || cmd_full;
   assign accept     = push && !full;
   assign space_byte = ttwc_pkg::is_space(data_byte);
   assign nul_byte   = (data_byte == ttwc_pkg::CHAR_NUL);
   assign wr_addr    = wr_ptr[AW-1:0];
   assign wr_data    = data_byte;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      start_in = start_ff;
      wr_en    = 1'b0;
      cmd_push = 1'b0;
      cmd      = '0;
      if (accept) begin
         unique case (mode_ff) inside
            MODE_SLASH, MODE_WORD: begin
               if ((mode_ff == MODE_SLASH) && (data_byte == ttwc_pkg::CHAR_SLASH)) begin
                  mode_in = MODE_COMMENT;
               end else if (space_byte) begin
                  cmd_push    = 1'b1;
                  cmd.has_tok = 1'b1;
                  cmd.discard = (count_ff >= CW'(TOKEN_MAX));
                  cmd.eos     = nul_byte;
                  cmd.len     = ttwc_pkg::LEN_W'(count_ff);
                  if (count_ff < CW'(TOKEN_MAX)) begin
                     start_in = start_ff + PW'(count_ff);
                  end
                  mode_in = MODE_SKIP;
               end else begin
                  mode_in = MODE_WORD;
                  if (count_ff < CW'(TOKEN_MAX)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end
            end
            MODE_COMMENT: begin
               if (nul_byte) begin
                  cmd_push = 1'b1;
                  cmd.eos  = 1'b1;
               end
               if (nul_byte || (data_byte == ttwc_pkg::CHAR_NEWLINE)) begin
                  mode_in = MODE_SKIP;
               end
            end
            MODE_QUOTED: begin
               if ((data_byte == ttwc_pkg::CHAR_QUOTE) || nul_byte) begin
                  cmd_push    = 1'b1;
                  cmd.has_tok = 1'b1;
                  cmd.discard = (count_ff == '0);
                  cmd.eos     = nul_byte;
                  cmd.len     = ttwc_pkg::LEN_W'(count_ff);
                  start_in    = start_ff + PW'(count_ff);
                  mode_in     = MODE_SKIP;
               end else if (count_ff < CW'(TOKEN_MAX - 1)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            default: begin
               mode_in = MODE_SKIP;
               if (nul_byte) begin
                  cmd_push = 1'b1;
                  cmd.eos  = 1'b1;
               end else if (space_byte) begin
                  mode_in = MODE_SKIP;
               end else if (data_byte == ttwc_pkg::CHAR_SLASH) begin
                  // The slash is stored at once; a second slash turns it into a comment.
                  wr_en    = 1'b1;
                  count_in = CW'(1);
                  mode_in  = MODE_SLASH;
               end else if (data_byte == ttwc_pkg::CHAR_QUOTE) begin
                  count_in = '0;
                  mode_in  = MODE_QUOTED;
               end else begin
                  wr_en    = 1'b1;
                  count_in = CW'(1);
                  mode_in  = MODE_WORD;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SKIP;
         count_ff <= '0;
         start_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         start_ff <= start_in;
      end
   end

endmodule

### sv/ttwc_back.sv
module ttwc_back #(
   parameter int RING_DEPTH = 128,
   parameter int OUT_DEPTH  = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ttwc_pkg::cmd_type               cmd,
   input  logic                            cmd_empty,
   output logic                            cmd_pop,
   output logic [$clog2(RING_DEPTH):0]     free_ptr,
   output logic                            rd_en,
   output logic [$clog2(RING_DEPTH)-1:0]   rd_addr,
   input  logic [7:0]                      rd_data,
   input  logic [$clog2(OUT_DEPTH):0]      out_level,
   output logic                            out_push,
   output ttwc_pkg::rsp_type               out_item
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int PW = AW + 1;
   localparam int LW = $clog2(OUT_DEPTH) + 1;

   logic [PW-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [ttwc_pkg::LEN_W-1:0]  idx_ff, idx_in;
   logic                        eos_phase_ff, eos_phase_in;
   logic                        s1_valid_ff;
   ttwc_pkg::rsp_type           s1_ff;
   ttwc_pkg::rsp_type           item;
   logic                        issue;
   logic                        byte_last;

   // A result may only be started if the output queue has room once the one in
   // flight behind the memory read has landed.
   assign issue     = !cmd_empty &&
                      ((out_level + LW'(s1_valid_ff)) < LW'(OUT_DEPTH));
   assign byte_last = (idx_ff == (cmd.len - ttwc_pkg::LEN_W'(1)));
   assign rd_addr   = rd_ptr_ff[AW-1:0];
   assign free_ptr  = rd_ptr_ff;

   always_comb begin
      item         = '0;
      cmd_pop      = 1'b0;
      rd_en        = 1'b0;
      rd_ptr_in    = rd_ptr_ff;
      idx_in       = idx_ff;
      eos_phase_in = eos_phase_ff;
      if (issue) begin
         if (eos_phase_ff || !cmd.has_tok) begin
            item.kind     = ttwc_pkg::KIND_EOS;
            item.run_last = 1'b1;
            cmd_pop       = 1'b1;
            eos_phase_in  = 1'b0;
         end else if (cmd.discard) begin
            item.kind       = ttwc_pkg::KIND_EMPTY;
            item.token_last = 1'b1;
            item.run_last   = !cmd.eos;
            if (cmd.eos) begin
               eos_phase_in = 1'b1;
            end else begin
               cmd_pop = 1'b1;
            end
         end else begin
            item.kind       = ttwc_pkg::KIND_BYTE;
            item.token_last = byte_last;
            item.run_last   = byte_last && !cmd.eos;
            rd_en           = 1'b1;
            rd_ptr_in       = rd_ptr_ff + PW'(1);
            if (byte_last) begin
               idx_in = '0;
               if (cmd.eos) begin
                  eos_phase_in = 1'b1;
               end else begin
                  cmd_pop = 1'b1;
               end
            end else begin
               idx_in = idx_ff + ttwc_pkg::LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         idx_ff       <= '0;
         eos_phase_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         idx_ff       <= idx_in;
         eos_phase_ff <= eos_phase_in;
         s1_valid_ff  <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff <= item;
      end
   end

   always_comb begin
      out_item = s1_ff;
      out_item.token_byte = (s1_ff.kind == ttwc_pkg::KIND_BYTE) ? rd_data : 8'h00;
   end

   assign out_push = s1_valid_ff;

endmodule

### sv/text_tokenizer_with_comments_top.sv
// Streaming text tokenizer with line comments and quoted strings.
//
// Input side: one text word per accepted push (push high, full low). A zero
// word ends the string. Bytes up to space and bytes with the top bit set are
// whitespace; a double slash at the start of a token skips to the newline;
// double quotes enclose a verbatim token; other runs form words.
// Result side: while empty is low the oldest result is on the rsp_ ports and is
// taken when pop is high. Each finished token comes out one word per cycle while
// the output queue has room, a discarded token as one empty result, then an
// end-of-string result where the string ended; run_last marks the last result
// caused by one input word.
// Throughput: the front end takes one word every cycle; it raises full only when
// the token ring (twice the token size, rounded up to a power of two) or the
// four-entry command queue is full. The back end gives one result per cycle
// while the output queue has room.
// Reset clears the scan mode, the queues and all pointers; empty is high and
// full low afterwards. When the receiver stalls, results queue up and the front
// end keeps scanning until the ring or the command queue fills.
module text_tokenizer_with_comments_top #(
   parameter int TOKEN_MAX = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] req_data_byte,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_token_last,
   output logic       rsp_run_last
);

   localparam int RING_DEPTH = 2 * (2 ** $clog2(TOKEN_MAX));
   localparam int AW         = $clog2(RING_DEPTH);
   localparam int CMD_DEPTH  = 4;
   localparam int OUT_DEPTH  = 4;
   localparam int CMD_W      = $bits(ttwc_pkg::cmd_type);
   localparam int RSP_W      = $bits(ttwc_pkg::rsp_type);

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [7:0]                 wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [7:0]                 rd_data;
   logic [AW:0]                free_ptr;
   logic                       cmd_full;
   logic                       cmd_push;
   logic                       cmd_empty;
   logic                       cmd_pop;
   ttwc_pkg::cmd_type          cmd_in;
   ttwc_pkg::cmd_type          cmd_head;
   logic [CMD_W-1:0]           cmd_head_vec;
   logic [$clog2(OUT_DEPTH):0] out_level;
   logic                       out_push;
   ttwc_pkg::rsp_type          out_item;
   logic [RSP_W-1:0]           rsp_vec;
   ttwc_pkg::rsp_type          rsp;

   ttwc_front #(
      .TOKEN_MAX  (TOKEN_MAX),
      .RING_DEPTH (RING_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data_byte (req_data_byte),
      .full      (full),
      .free_ptr  (free_ptr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd       (cmd_in)
   );

   ttwc_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ttwc_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head_vec),
      .empty     (cmd_empty),
      .level     ()
   );

   assign cmd_head = ttwc_pkg::cmd_type'(cmd_head_vec);

   ttwc_back #(
      .RING_DEPTH (RING_DEPTH),
      .OUT_DEPTH  (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .free_ptr  (free_ptr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_level (out_level),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   ttwc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (),
      .pop       (pop),
      .pop_data  (rsp_vec),
      .empty     (empty),
      .level     (out_level)
   );

   assign rsp            = ttwc_pkg::rsp_type'(rsp_vec);
   assign rsp_kind       = rsp.kind;
   assign rsp_token_byte = rsp.token_byte;
   assign rsp_token_last = rsp.token_last;
   assign rsp_run_last   = rsp.run_last;

endmodule

### sv/ttwc_checker.sv
module ttwc_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       pop,
   input logic       empty,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_token_byte,
   input logic       rsp_token_last,
   input logic       rsp_run_last
);

   a_after_reset: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not clear after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_kind) && $stable(rsp_token_byte) &&
                            $stable(rsp_token_last) && $stable(rsp_run_last)))
      else $error("result changed while stalled");

   a_eos_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_kind == ttwc_pkg::KIND_EOS)) |->
      (rsp_run_last && !rsp_token_last && (rsp_token_byte == 8'h00)))
      else $error("malformed end-of-string result");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_kind == ttwc_pkg::KIND_EMPTY)) |->
      (rsp_token_last && (rsp_token_byte == 8'h00)))
      else $error("malformed empty token result");

   a_mid_token: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_kind == ttwc_pkg::KIND_BYTE) && !rsp_token_last) |-> !rsp_run_last)
      else $error("run ended inside a token");

endmodule

bind text_tokenizer_with_comments_top ttwc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .full           (full),
   .pop            (pop),
   .empty          (empty),
   .rsp_kind       (rsp_kind),
   .rsp_token_byte (rsp_token_byte),
   .rsp_token_last (rsp_token_last),
   .rsp_run_last   (rsp_run_last)
);

### dv/text_tokenizer_with_comments_top_test.sv
`timescale 1ns / 1ps
module text_tokenizer_with_comments_top_test;

   localparam int TOKEN_MAX       = 64;
   localparam int TOTAL_ITEMS     = 330;
   localparam int IDLE_PCT        = 23;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 20;
   localparam int CYCLE_LIMIT     = 200000;

   typedef enum logic [2:0] {
      SCAN_SKIP, SCAN_SLASH, SCAN_COMMENT, SCAN_QUOTED, SCAN_WORD
   } scan_type;

   // A short word closed by a high byte, a comment, a lone slash growing into a
   // word with slashes in it, empty quotes, a zero inside quotes, a zero ending a
   // word, a zero inside a comment, a bare zero and a slash standing alone.
   localparam logic [7:0] OPENING [0:25] = '{
      8'h21, 8'h7F, 8'h80, ttwc_pkg::CHAR_SPACE,
      ttwc_pkg::CHAR_SLASH, ttwc_pkg::CHAR_SLASH, "x", ttwc_pkg::CHAR_NEWLINE,
      ttwc_pkg::CHAR_SLASH, "b", ttwc_pkg::CHAR_SLASH, ttwc_pkg::CHAR_SLASH, 8'h01,
      ttwc_pkg::CHAR_QUOTE, ttwc_pkg::CHAR_QUOTE,
      ttwc_pkg::CHAR_QUOTE, 8'hFF, ttwc_pkg::CHAR_NUL,
      "z", ttwc_pkg::CHAR_NUL,
      ttwc_pkg::CHAR_SLASH, ttwc_pkg::CHAR_SLASH, ttwc_pkg::CHAR_NUL,
      ttwc_pkg::CHAR_NUL,
      ttwc_pkg::CHAR_SLASH, ttwc_pkg::CHAR_SPACE
   };

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       push          = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       pop           = 1'b0;
   logic       full;
   logic       empty;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_token_byte;
   logic       rsp_token_last;
   logic       rsp_run_last;

   // Tokenizer state as predicted.
   scan_type          scan_state = SCAN_SKIP;
   logic [7:0]        token_buf [TOKEN_MAX];
   logic [6:0]        token_len = '0;
   ttwc_pkg::rsp_type fresh [$];
   ttwc_pkg::rsp_type awaited [$];
   ttwc_pkg::rsp_type want;

   logic [7:0] pending [$];
   int         stim_count  = 0;
   int         sent_count  = 0;
   int         got_count   = 0;
   int         hold_left   = 0;
   int         failures    = 0;
   int         cycle_count = 0;

   text_tokenizer_with_comments_top #(.TOKEN_MAX(TOKEN_MAX)) DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .req_data_byte(req_data_byte),
      .full(full),
      .pop(pop),
      .empty(empty),
      .rsp_kind(rsp_kind),
      .rsp_token_byte(rsp_token_byte),
      .rsp_token_last(rsp_token_last),
      .rsp_run_last(rsp_run_last)
   );

   always #1 clock = ~clock;

   function automatic logic blank(input logic [7:0] b);
      return (b <= ttwc_pkg::CHAR_SPACE) || (b >= 8'h80);
   endfunction

   task automatic note_result(input logic [1:0] kind, input logic [7:0] b, input logic last);
      ttwc_pkg::rsp_type r;
      r.kind       = kind;
      r.token_byte = b;
      r.token_last = last;
      r.run_last   = 1'b0;
      fresh.push_back(r);
   endtask

   task automatic emit_token(input logic discard);
      if (discard || token_len == 0) begin
         note_result(ttwc_pkg::KIND_EMPTY, 8'h00, 1'b1);
      end else begin
         for (int i = 0; i < token_len; i++)
            note_result(ttwc_pkg::KIND_BYTE, token_buf[i], (i + 1 == token_len));
      end
   endtask

   task automatic keep_byte(input logic [7:0] b, input int limit);
      if (token_len < limit) begin
         token_buf[token_len] = b;
         token_len++;
      end
   endtask

   task automatic word_byte(input logic [7:0] b);
      if (blank(b)) begin
         emit_token(token_len >= TOKEN_MAX);
         if (b == ttwc_pkg::CHAR_NUL)
            note_result(ttwc_pkg::KIND_EOS, 8'h00, 1'b0);
         scan_state = SCAN_SKIP;
      end else begin
         keep_byte(b, TOKEN_MAX);
      end
   endtask

   // Advances the predicted tokenizer by one word and queues what it yields.
   task automatic tokenize(input logic [7:0] b);
      fresh.delete();
      case (scan_state)
         SCAN_SLASH: begin
            if (b == ttwc_pkg::CHAR_SLASH) begin
               scan_state = SCAN_COMMENT;
            end else begin
               // The slash did not open a comment, so it heads a word instead.
               token_len = '0;
               keep_byte(ttwc_pkg::CHAR_SLASH, TOKEN_MAX);
               scan_state = SCAN_WORD;
               word_byte(b);
            end
         end
         SCAN_WORD: word_byte(b);
         SCAN_COMMENT: begin
            if (b == ttwc_pkg::CHAR_NUL)
               note_result(ttwc_pkg::KIND_EOS, 8'h00, 1'b0);
            if (b == ttwc_pkg::CHAR_NUL || b == ttwc_pkg::CHAR_NEWLINE)
               scan_state = SCAN_SKIP;
         end
         SCAN_QUOTED: begin
            if (b == ttwc_pkg::CHAR_QUOTE) begin
               emit_token(1'b0);
               scan_state = SCAN_SKIP;
            end else if (b == ttwc_pkg::CHAR_NUL) begin
               emit_token(1'b0);
               note_result(ttwc_pkg::KIND_EOS, 8'h00, 1'b0);
               scan_state = SCAN_SKIP;
            end else begin
               keep_byte(b, TOKEN_MAX - 1);
            end
         end
         default: begin
            scan_state = SCAN_SKIP;
            if (b == ttwc_pkg::CHAR_NUL) begin
               note_result(ttwc_pkg::KIND_EOS, 8'h00, 1'b0);
            end else if (!blank(b)) begin
               if (b == ttwc_pkg::CHAR_SLASH) begin
                  scan_state = SCAN_SLASH;
               end else if (b == ttwc_pkg::CHAR_QUOTE) begin
                  token_len = '0;
                  scan_state = SCAN_QUOTED;
               end else begin
                  token_len = '0;
                  keep_byte(b, TOKEN_MAX);
                  scan_state = SCAN_WORD;
               end
            end
         end
      endcase
      if (fresh.size() != 0)
         fresh[fresh.size() - 1].run_last = 1'b1;
      foreach (fresh[i])
         awaited.push_back(fresh[i]);
   endtask

   // Stimulus building blocks.
   task automatic queue_byte(input logic [7:0] b);
      pending.push_back(b);
      stim_count++;
   endtask

   function automatic logic [7:0] any_blank();
      if ($urandom_range(1) == 0)
         return 8'($urandom_range(32, 1));
      return 8'($urandom_range(255, 128));
   endfunction

   function automatic logic [7:0] pick_except(input int lo, input int hi, input logic [7:0] bar);
      logic [7:0] b;
      do
         b = 8'($urandom_range(hi, lo));
      while (b == bar);
      return b;
   endfunction

   function automatic logic [7:0] word_head();
      logic [7:0] b;
      do
         b = 8'($urandom_range(8'h7F, 8'h21));
      while (b == ttwc_pkg::CHAR_SLASH || b == ttwc_pkg::CHAR_QUOTE);
      return b;
   endfunction

   task automatic queue_word(input int len, input logic [7:0] head);
      queue_byte(head);
      for (int k = 1; k < len; k++)
         queue_byte(8'($urandom_range(8'h7F, 8'h21)));
      queue_byte(($urandom_range(5) == 0) ? ttwc_pkg::CHAR_NUL : any_blank());
   endtask

   task automatic queue_quoted(input int len);
      queue_byte(ttwc_pkg::CHAR_QUOTE);
      for (int k = 0; k < len; k++)
         queue_byte(pick_except(1, 255, ttwc_pkg::CHAR_QUOTE));
      queue_byte(($urandom_range(7) == 0) ? ttwc_pkg::CHAR_NUL : ttwc_pkg::CHAR_QUOTE);
   endtask

   task automatic queue_segment();
      int pick;
      int len;
      pick = $urandom_range(99);
      len  = $urandom_range(8, 1);
      if (pick < 30) begin
         queue_word(len, word_head());
      end else if (pick < 50) begin
         queue_quoted($urandom_range(8, 0));
      end else if (pick < 62) begin
         queue_byte(ttwc_pkg::CHAR_SLASH);
         queue_byte(ttwc_pkg::CHAR_SLASH);
         for (int k = 0; k < len; k++)
            queue_byte(pick_except(1, 255, ttwc_pkg::CHAR_NEWLINE));
         queue_byte(($urandom_range(5) == 0) ? ttwc_pkg::CHAR_NUL : ttwc_pkg::CHAR_NEWLINE);
      end else if (pick < 70) begin
         queue_byte(ttwc_pkg::CHAR_SLASH);
         queue_word(len, pick_except(8'h21, 8'h7F, ttwc_pkg::CHAR_SLASH));
      end else if (pick < 78) begin
         queue_byte(ttwc_pkg::CHAR_NUL);
      end else if (pick < 85) begin
         for (int k = 0; k < len; k++)
            queue_byte(any_blank());
      end else begin
         for (int k = 0; k < len; k++)
            queue_byte(8'($urandom_range(255, 0)));
      end
   endtask

   task automatic wait_idle();
      while (pending.size() != 0 || push || awaited.size() != 0)
         @(posedge clock);
   endtask

   // Sender.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            tokenize(req_data_byte);
            sent_count++;
         end
         if (!push || !full) begin
            if (pending.size() != 0 &&
                ((sent_count >= 150 && sent_count < 230) || $urandom_range(99) >= IDLE_PCT)) begin
               push <= 1'b1;
               req_data_byte <= pending.pop_front();
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Receiver and checker.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (awaited.size() == 0) begin
               $display("%0t: unexpected result: kind %0d byte %h last %b run_last %b",
                        $time, rsp_kind, rsp_token_byte, rsp_token_last, rsp_run_last);
               failures++;
            end else begin
               want = awaited.pop_front();
               if (rsp_kind !== want.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_kind);
                  failures++;
               end
               if (rsp_token_byte !== want.token_byte) begin
                  $display("%0t: token_byte expected %h actual %h",
                           $time, want.token_byte, rsp_token_byte);
                  failures++;
               end
               if (rsp_token_last !== want.token_last) begin
                  $display("%0t: token_last expected %b actual %b",
                           $time, want.token_last, rsp_token_last);
                  failures++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $display("%0t: run_last expected %b actual %b",
                           $time, want.run_last, rsp_run_last);
                  failures++;
               end
            end
            got_count++;
            // A long hold-off while the long tokens stream in lets the token ring
            // and command queue fill up.
            if (got_count == 40)
               hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= (got_count >= 100 && got_count < 170) || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (OPENING[i])
         queue_byte(OPENING[i]);
      wait_idle();

      // Tokens at the size limits: a word just kept, a word just discarded, a
      // quoted token that just fits and one that is cut short.
      queue_word(TOKEN_MAX - 1, word_head());
      queue_word(TOKEN_MAX, word_head());
      queue_quoted(TOKEN_MAX - 1);
      queue_quoted(TOKEN_MAX + 2);

      while (stim_count < TOTAL_ITEMS)
         queue_segment();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && awaited.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
